// ===== src/cfd_pkg.sv =====
package cfd_pkg;

  // Fixed field widths of the ports
  localparam int MOD_BITS  = 26;
  localparam int BASE_BITS = 9;

  // Delay register after reset, in whole samples
  localparam logic [BASE_BITS-1:0] BASE_RESET = 9'd16;

  // Modulation may swing to within this many samples of the base delay
  localparam logic [BASE_BITS-1:0] CLAMP_MARGIN = 9'd4;

  // Interpolation neighbors, one per ring bank
  localparam int TAPS = 4;

  // Load enables for the interpolation stages
  typedef struct packed {
    logic coef;
    logic mul1;
    logic mul2;
    logic mul3;
    logic fin;
  } cfd_adv_t;

endpackage

// ===== src/cfd_bank.sv =====
module cfd_bank #(
  parameter int ROWS      = 256,
  parameter int DATA_BITS = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(ROWS)-1:0]  waddr,
  input  logic [DATA_BITS-1:0]     wdata,
  input  logic                     re,
  input  logic [$clog2(ROWS)-1:0]  raddr,
  output logic [DATA_BITS-1:0]     rdata
);

  logic [DATA_BITS-1:0] mem [ROWS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cfd_horner.sv =====
module cfd_horner #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  cfd_pkg::cfd_adv_t             adv,
  input  logic signed [SAMPLE_BITS-1:0] taps [cfd_pkg::TAPS],
  input  logic [FRAC_BITS-1:0]          frac,
  input  logic                          warm,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          warming_up
);
  import cfd_pkg::*;

  // Coefficient and Horner accumulator width, product width
  localparam int CW = SAMPLE_BITS + 5;
  localparam int PW = CW + FRAC_BITS + 1;
  localparam int PX = PW + 1;
  localparam logic signed [PX-1:0] HALF = PX'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CW-1:0] SMAX =
    {{(CW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN =
    {{(CW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Round half up and drop the fraction bits
  function automatic logic signed [CW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PX-1:0] s;
    s = PX'(p) + HALF;
    return CW'(s >>> FRAC_BITS);
  endfunction

  logic signed [CW-1:0] y0, y1, y2, y3;
  logic signed [CW-1:0] d12;

  // Coefficient stage
  logic signed [CW-1:0] c1a, c2a, c3a, y1a;
  logic [FRAC_BITS-1:0] ta;
  logic                 warma;

  // First product stage
  logic signed [PW-1:0] p1;
  logic signed [CW-1:0] c1b, c2b, y1b;
  logic [FRAC_BITS-1:0] tb;
  logic                 warmb;

  // Second product stage
  logic signed [PW-1:0] p2;
  logic signed [CW-1:0] c1c, y1c;
  logic [FRAC_BITS-1:0] tc;
  logic                 warmc;

  // Third product stage
  logic signed [PW-1:0] p3;
  logic signed [CW-1:0] y1d;
  logic                 warmd;

  logic signed [CW-1:0] h1, h2, h3, y_full;

  assign y0  = CW'(taps[0]);
  assign y1  = CW'(taps[1]);
  assign y2  = CW'(taps[2]);
  assign y3  = CW'(taps[3]);
  assign d12 = y1 - y2;

  // Form the doubled Catmull-Rom coefficients
  always_ff @(posedge clk) begin
    if (adv.coef) begin
      c1a   <= y2 - y0;
      c2a   <= (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
      c3a   <= (y3 - y0) + (d12 <<< 1) + d12;
      y1a   <= y1;
      ta    <= frac;
      warma <= warm;
    end
  end

  // Cubic term times the fraction
  always_ff @(posedge clk) begin
    if (adv.mul1) begin
      p1    <= PW'(c3a) * PW'(signed'({1'b0, ta}));
      c1b   <= c1a;
      c2b   <= c2a;
      y1b   <= y1a;
      tb    <= ta;
      warmb <= warma;
    end
  end

  assign h1 = rnd(p1) + c2b;

  // Quadratic step
  always_ff @(posedge clk) begin
    if (adv.mul2) begin
      p2    <= PW'(h1) * PW'(signed'({1'b0, tb}));
      c1c   <= c1b;
      y1c   <= y1b;
      tc    <= tb;
      warmc <= warmb;
    end
  end

  assign h2 = rnd(p2) + c1c;

  // Linear step
  always_ff @(posedge clk) begin
    if (adv.mul3) begin
      p3    <= PW'(h2) * PW'(signed'({1'b0, tc}));
      y1d   <= y1c;
      warmd <= warmc;
    end
  end

  // Halve the doubled sum with rounding and add the base tap
  assign h3     = rnd(p3);
  assign y_full = y1d + ((h3 + CW'(1)) >>> 1);

  // Saturate into the result register, zero during warm-up
  always_ff @(posedge clk) begin
    if (adv.fin) begin
      warming_up <= warmd;
      if (warmd) begin
        sample_out <= '0;
      end else if (y_full > SMAX) begin
        sample_out <= SMAX[SAMPLE_BITS-1:0];
      end else if (y_full < SMIN) begin
        sample_out <= SMIN[SAMPLE_BITS-1:0];
      end else begin
        sample_out <= y_full[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// ===== src/cubic_fractional_delay.sv =====
// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   base_delay (always ready)
// in        in_valid / in_ready     sample_in, mod_offset
// out       out_valid / out_ready   sample_out, warming_up
//
// One item per cycle sustained while the output is not held; a result passes through
// nine registers from its input transfer (input, clamp, offset, ring read, coefficients,
// three multiplies, result; the input register loads at the transfer edge).
// The ring is split into four banks so the four neighbors come from one read each.
// Reset clears control only; ring entries not yet written read as zero by the fill
// count, so there is no clearing pass.
// A held result stops only the stages behind it that are full; bubbles collapse.
module cubic_fractional_delay #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cfd_pkg::BASE_BITS-1:0]      base_delay,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in,
  input  logic signed [cfd_pkg::MOD_BITS-1:0] mod_offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic                               warming_up
);
  import cfd_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int ROWS = DEPTH / TAPS;
  localparam int LW   = (FRAC_BITS + 10 > MOD_BITS) ? FRAC_BITS + 10 : MOD_BITS;
  localparam int VW   = LW + 2;
  localparam int RW   = VW - FRAC_BITS;
  localparam int RXW  = ((RW > AW) ? RW : AW) + 1;
  localparam int WW   = RXW + 2;
  localparam int NST  = 8;

  // Write head, fill count and delay register
  logic [AW-1:0]        wp;
  logic [AW:0]          cnt;
  logic [BASE_BITS-1:0] base;

  // Stage valid bits and load enables
  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  cfd_adv_t       adv;

  // Input stage
  logic signed [SAMPLE_BITS-1:0] s0_smp;
  logic signed [MOD_BITS-1:0]    s0_mod;
  logic [AW-1:0]                 s0_wp;
  logic [AW:0]                   s0_cnt;
  logic [BASE_BITS-1:0]          s0_base;

  // Clamp stage
  logic signed [LW-1:0]          lim, neg_lim, mod_x, mod_c;
  logic signed [LW-1:0]          s1_mod;
  logic signed [SAMPLE_BITS-1:0] s1_smp;
  logic [AW-1:0]                 s1_wp;
  logic [AW:0]                   s1_cnt;
  logic [BASE_BITS-1:0]          s1_base;

  // Offset stage
  logic signed [VW-1:0]          v;
  logic signed [RW-1:0]          s2_r;
  logic [FRAC_BITS-1:0]          s2_t;
  logic signed [SAMPLE_BITS-1:0] s2_smp;
  logic [AW-1:0]                 s2_wp;
  logic [AW:0]                   s2_cnt;

  // Ring read stage
  logic signed [RXW-1:0]         rx;
  logic signed [WW-1:0]          pos;
  logic [AW-1:0]                 a;
  logic [AW-1:0]                 e    [TAPS];
  logic [AW-3:0]                 rrow [TAPS];
  logic [TAPS-1:0]               fwd, ok, we;
  logic [1:0]                    idx  [TAPS];
  logic                          warm_c, wr_en;
  logic [TAPS-1:0]               s3_fwd, s3_ok;
  logic [1:0]                    s3_ph;
  logic [FRAC_BITS-1:0]          s3_t;
  logic signed [SAMPLE_BITS-1:0] s3_smp;
  logic                          s3_warm;
  logic [SAMPLE_BITS-1:0]        rd   [TAPS];
  logic signed [SAMPLE_BITS-1:0] taps [TAPS];

  assign cfg_ready = 1'b1;

  // Hold the delay register; a transfer replaces it
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_valid) begin
      base <= base_delay;
    end
  end

  // Each stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NST] = !out_valid || out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];
  assign adv.coef = rdy[4];
  assign adv.mul1 = rdy[5];
  assign adv.mul2 = rdy[6];
  assign adv.mul3 = rdy[7];
  assign adv.fin  = rdy[8];

  // Advance valid bits, write head and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      wp        <= '0;
      cnt       <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[NST]) begin
        out_valid <= vld[NST-1];
      end
      if (in_valid && rdy[0]) begin
        wp <= wp + AW'(1);
        if (!cnt[AW]) begin
          cnt <= cnt + (AW+1)'(1);
        end
      end
    end
  end

  // Capture the transfer with its write slot
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_smp  <= sample_in;
      s0_mod  <= mod_offset;
      s0_wp   <= wp;
      s0_cnt  <= cnt;
      s0_base <= base;
    end
  end

  // Clamp the modulation to within the base delay less the margin
  always_comb begin
    if (s0_base > CLAMP_MARGIN) begin
      lim = LW'({s0_base - CLAMP_MARGIN, {FRAC_BITS{1'b0}}});
    end else begin
      lim = '0;
    end
    neg_lim = -lim;
    mod_x   = LW'(s0_mod);
    if (mod_x > lim) begin
      mod_c = lim;
    end else if (mod_x < neg_lim) begin
      mod_c = neg_lim;
    end else begin
      mod_c = mod_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_mod  <= mod_c;
      s1_smp  <= s0_smp;
      s1_wp   <= s0_wp;
      s1_cnt  <= s0_cnt;
      s1_base <= s0_base;
    end
  end

  // Read position relative to the write head: whole part and fraction
  assign v = VW'(s1_mod) - VW'(signed'({1'b0, s1_base, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_r   <= v[VW-1:FRAC_BITS];
      s2_t   <= v[FRAC_BITS-1:0];
      s2_smp <= s1_smp;
      s2_wp  <= s1_wp;
      s2_cnt <= s1_cnt;
    end
  end

  // Tap addresses, bank rows, forwarding and fill checks
  always_comb begin
    rx     = RXW'(s2_r);
    pos    = WW'(signed'({1'b0, s2_cnt})) + WW'(rx);
    warm_c = pos[WW-1] || (pos == '0);
    a      = s2_wp + rx[AW-1:0];
    for (int j = 0; j < TAPS; j++) begin
      e[j]   = a + AW'(j) - AW'(1);
      fwd[j] = (e[j] == s2_wp);
      ok[j]  = s2_cnt[AW] || ({1'b0, e[j]} < s2_cnt);
    end
    for (int b = 0; b < TAPS; b++) begin
      idx[b]  = 2'(b) - e[0][1:0];
      rrow[b] = e[idx[b]][AW-1:2];
      we[b]   = wr_en && (s2_wp[1:0] == 2'(b));
    end
  end

  // Store the sample as its item leaves the offset stage
  assign wr_en = vld[2] && rdy[3];

  for (genvar b = 0; b < TAPS; b++) begin : g_bank
    cfd_bank #(
      .ROWS      (ROWS),
      .DATA_BITS (SAMPLE_BITS)
    ) u_bank (
      .clk   (clk),
      .we    (we[b]),
      .waddr (s2_wp[AW-1:2]),
      .wdata (s2_smp),
      .re    (rdy[3]),
      .raddr (rrow[b]),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_fwd  <= fwd;
      s3_ok   <= ok;
      s3_ph   <= e[0][1:0];
      s3_t    <= s2_t;
      s3_smp  <= s2_smp;
      s3_warm <= warm_c;
    end
  end

  // Rotate bank outputs into tap order; drop unwritten entries to zero
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      if (s3_fwd[j]) begin
        taps[j] = s3_smp;
      end else if (s3_ok[j]) begin
        taps[j] = signed'(rd[s3_ph + 2'(j)]);
      end else begin
        taps[j] = '0;
      end
    end
  end

  cfd_horner #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_horner (
    .clk        (clk),
    .adv        (adv),
    .taps       (taps),
    .frac       (s3_t),
    .warm       (s3_warm),
    .sample_out (sample_out),
    .warming_up (warming_up)
  );

endmodule

// ===== verif/cubic_fractional_delay_test.sv =====
module cubic_fractional_delay_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int SBITS       = 24;
  localparam int FRAC        = 16;
  localparam int MOD_W       = cfd_pkg::MOD_BITS;
  localparam int BASE_W      = cfd_pkg::BASE_BITS;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  localparam logic [SBITS-1:0] S_MAX = {1'b0, {(SBITS-1){1'b1}}};
  localparam logic [SBITS-1:0] S_MIN = {1'b1, {(SBITS-1){1'b0}}};
  localparam logic [MOD_W-1:0] M_MAX = {1'b0, {(MOD_W-1){1'b1}}};
  localparam logic [MOD_W-1:0] M_MIN = {1'b1, {(MOD_W-1){1'b0}}};

  typedef struct {
    logic signed [SBITS-1:0] sample;
    logic                    warm;
  } delay_out_t;

  // Cubic delay line predictor and the queue of samples it still owes
  class delay_scoreboard;
    logic signed [SBITS-1:0] ring [DEPTH];
    logic [9:0]              wr_ptr;
    logic [10:0]             fill;
    logic [BASE_W-1:0]       base;
    delay_out_t              expected_q [$];
    int                      errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = '0;
      fill   = '0;
      base   = cfd_pkg::BASE_RESET;
      errors = 0;
    endfunction

    function void set_base(logic [BASE_W-1:0] b);
      base = b;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    static function longint round_half_up(longint x, int sh);
      return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Store the sample, read four taps around the delayed position, interpolate
    function void note_input(logic signed [SBITS-1:0] s, logic signed [MOD_W-1:0] m);
      longint     lim, md, v, pos, t, y0, y1, y2, y3, c1, c2, c3, h, y;
      logic [9:0] a;
      delay_out_t r;
      ring[wr_ptr] = s;
      lim = (base > cfd_pkg::CLAMP_MARGIN) ?
            (longint'(base) - longint'(cfd_pkg::CLAMP_MARGIN)) <<< FRAC : 0;
      md = m;
      if (md > lim) md = lim;
      if (md < -lim) md = -lim;
      v   = md - (longint'(base) <<< FRAC);
      pos = (longint'(fill) <<< FRAC) + v;
      t   = v & ((longint'(1) <<< FRAC) - 1);
      a   = wr_ptr + 10'(v >>> FRAC);
      y0  = ring[10'(a - 10'd1)];
      y1  = ring[a];
      y2  = ring[10'(a + 10'd1)];
      y3  = ring[10'(a + 10'd2)];
      wr_ptr = wr_ptr + 10'd1;
      if (fill < DEPTH) fill = fill + 11'd1;
      if (pos < (longint'(1) <<< FRAC)) begin
        r.sample = '0;
        r.warm   = 1'b1;
      end else begin
        c1 = y2 - y0;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c3 = (y3 - y0) + 3 * (y1 - y2);
        h  = round_half_up(c3 * t, FRAC) + c2;
        h  = round_half_up(h * t, FRAC) + c1;
        h  = round_half_up(h * t, FRAC);
        y  = y1 + round_half_up(h, 1);
        if (y > longint'(S_MAX)) y = longint'(S_MAX);
        if (y < -longint'(S_MAX) - 1) y = -longint'(S_MAX) - 1;
        r.sample = y[SBITS-1:0];
        r.warm   = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(logic signed [SBITS-1:0] s, logic w);
      delay_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result sample_out=%0d warming_up=%0b", $time, s, w);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, s);
        errors++;
      end
      if (w !== e.warm) begin
        $display("%0t: warming_up expected %0b actual %0b", $time, e.warm, w);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [BASE_W-1:0]        base_delay;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [SBITS-1:0]  sample_in;
  logic signed [MOD_W-1:0]  mod_offset;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [SBITS-1:0]  sample_out;
  logic                     warming_up;

  delay_scoreboard          sb;
  bit                       no_gaps;
  logic signed [SBITS-1:0]  prev_sample;
  int                       sink_left;
  int                       quiet;

  cubic_fractional_delay i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .base_delay (base_delay),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .mod_offset (mod_offset),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .warming_up (warming_up)
  );

  always #5 clk = ~clk;

  // Mostly short runs, a few long ones
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 94) return $urandom_range(3, 10);
    if (r < 98) return $urandom_range(20, 60);
    return $urandom_range(100, 300);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Mix of noise, full-scale square waves, slow ramps and near-zero samples
  function automatic logic [SBITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) prev_sample = SBITS'($urandom);
    else if (r < 65) prev_sample = prev_sample[SBITS-1] ? S_MAX : S_MIN;
    else if (r < 90)
      prev_sample = SBITS'(int'(prev_sample) + int'($urandom_range(0, 8192)) - 4096);
    else prev_sample = SBITS'(int'($urandom_range(0, 2)) - 1);
    return prev_sample;
  endfunction

  // Mostly modulation inside the clamp range with random fraction
  function automatic logic [MOD_W-1:0] pick_mod(int b);
    int               lim_s, r, whole;
    logic [MOD_W-1:0] m;
    lim_s = (b > int'(cfd_pkg::CLAMP_MARGIN)) ? b - int'(cfd_pkg::CLAMP_MARGIN) : 0;
    r = $urandom_range(0, 99);
    if (r < 15) m = MOD_W'($urandom);
    else if (r < 25) begin
      case ($urandom_range(0, 5))
        0: m = M_MAX;
        1: m = M_MIN;
        2: m = MOD_W'(lim_s * 65536);
        3: m = MOD_W'(-lim_s * 65536);
        4: m = MOD_W'(lim_s * 65536 + 1);
        default: m = MOD_W'(-lim_s * 65536 - 1);
      endcase
    end else if (r < 80) begin
      whole = int'($urandom_range(0, 2 * lim_s)) - lim_s;
      m = MOD_W'(whole * 65536 + int'($urandom_range(0, 65535)));
    end else m = MOD_W'(int'($urandom_range(0, 131071)) - 65536);
    return m;
  endfunction

  // Hold one input item until its transfer, then maybe idle
  task automatic push_sample(input logic [SBITS-1:0] s, input logic [MOD_W-1:0] m);
    int gap;
    in_valid   <= 1'b1;
    sample_in  <= s;
    mod_offset <= m;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted sample has come out
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_base_delay(input logic [BASE_W-1:0] b);
    cfg_valid  <= 1'b1;
    base_delay <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] b, input int n, input bit pause_mid);
    wait_results_done();
    write_base_delay(b);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) no_gaps = 1'b1;
      if (i == n / 2) no_gaps = 1'b0;
      if (pause_mid && i == (n * 3) / 4) wait_results_done();
      push_sample(pick_sample(), pick_mod(int'(b)));
    end
  endtask

  // Receiver: random ready and stall runs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_left <= 0;
    end else if (sink_left == 0) begin
      out_ready <= ($urandom_range(0, 9) < 7);
      sink_left <= pick_len();
    end else begin
      sink_left <= sink_left - 1;
    end
  end

  // Observe every transfer; end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_base(base_delay);
      if (in_valid && in_ready) sb.note_input(sample_in, mod_offset);
      if (out_valid && out_ready) sb.check_result(sample_out, warming_up);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else
        quiet <= quiet + 1;
    end
  end

  initial begin
    sb          = new();
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    base_delay  = cfd_pkg::BASE_RESET;
    in_valid    = 1'b0;
    sample_in   = '0;
    mod_offset  = '0;
    out_ready   = 1'b0;
    no_gaps     = 1'b0;
    prev_sample = '0;
    quiet       = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset base of 16: warm-up, its boundary, clamp edges, full-scale swings
    push_sample(S_MAX, M_MAX);
    push_sample(S_MIN, M_MIN);
    push_sample('0, '0);
    push_sample({SBITS{1'b1}}, MOD_W'(1));
    push_sample(S_MAX, {MOD_W{1'b1}});
    push_sample(S_MIN, MOD_W'(12 * 65536 - 1));
    push_sample(S_MAX, MOD_W'(12 * 65536));
    push_sample(S_MIN, M_MAX);
    push_sample(S_MAX, MOD_W'(12 * 65536 - 32768));
    push_sample(S_MIN, MOD_W'(12 * 65536 - 32768));
    push_sample(S_MAX, MOD_W'(-12 * 65536));
    push_sample(S_MIN, MOD_W'(12 * 65536 - 16384));
    push_sample(S_MAX, MOD_W'(12 * 65536 - 16384));
    push_sample(S_MIN, MOD_W'(12 * 65536 - 49152));
    push_sample(S_MAX, MOD_W'(12 * 65536 - 1));
    push_sample('0, MOD_W'(32768));

    // Small bases ignore modulation; base 5 clamps to one sample
    wait_results_done();
    write_base_delay('0);
    push_sample(S_MAX, M_MAX);
    push_sample(S_MIN, M_MIN);
    wait_results_done();
    write_base_delay(BASE_W'(4));
    push_sample(S_MAX, M_MIN);
    push_sample(S_MIN, M_MAX);
    wait_results_done();
    write_base_delay(BASE_W'(5));
    push_sample(S_MAX, M_MAX);
    push_sample(S_MIN, M_MIN);
    push_sample(S_MAX, MOD_W'(32768));

    // Random phases; the largest base comes first to stretch the warm-up
    run_phase(BASE_W'(511), 400, 1'b0);
    run_phase(BASE_W'(8), 172, 1'b1);
    run_phase(BASE_W'(504), 172, 1'b0);
    run_phase('0, 172, 1'b0);
    run_phase(BASE_W'(5), 172, 1'b1);
    run_phase(BASE_W'(4), 172, 1'b0);
    run_phase(BASE_W'(1), 172, 1'b0);
    run_phase(BASE_W'($urandom_range(8, 504)), 172, 1'b0);
    run_phase(BASE_W'($urandom_range(9, 64)), 172, 1'b1);
    run_phase(BASE_W'(300), 172, 1'b0);

    // Drain and let the pipeline settle before the verdict
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
